FILE: rtl/srr_pkg.sv
// Shared types and constants of the selective repeat receiver.
`timescale 1ns / 1ps
package srr_pkg;

  // Packet field widths
  localparam int SEQ_W     = 31;
  localparam int CHECK_W   = 32;
  localparam int LOW_W     = 64;
  localparam int MID_W     = 64;
  localparam int TOP_W     = 32;
  localparam int PAYLOAD_W = LOW_W + MID_W + TOP_W;
  localparam int CFG_W     = 5;

  // Checksum is summed in groups of bytes, one group per adder chain
  localparam int GROUPS    = 4;
  localparam int GROUP_LEN = 5;
  localparam int GROUP_W   = 11;

  // Base saturates here
  localparam logic [SEQ_W-1:0] BASE_MAX = {SEQ_W{1'b1}};

  // Reset value of the window register
  localparam logic [CFG_W-1:0] WINDOW_RESET = 5'd8;

  // Hand-off queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Result kinds
  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_DELIVER = 1'b1;

endpackage

FILE: rtl/srr_if.sv
// Packet and result channel interfaces.
`timescale 1ns / 1ps
interface srr_pkt_if;
  logic                        valid;
  logic                        ready;
  logic [srr_pkg::SEQ_W-1:0]   seq_number;
  logic [srr_pkg::SEQ_W-1:0]   ack_number;
  logic signed [srr_pkg::CHECK_W-1:0] check_value;
  logic [srr_pkg::LOW_W-1:0]   payload_low;
  logic [srr_pkg::MID_W-1:0]   payload_mid;
  logic [srr_pkg::TOP_W-1:0]   payload_top;

  modport source (output valid, seq_number, ack_number, check_value,
                  payload_low, payload_mid, payload_top, input ready);
  modport sink   (input valid, seq_number, ack_number, check_value,
                  payload_low, payload_mid, payload_top, output ready);
endinterface

interface srr_res_if;
  logic valid;
  logic ready;
  logic kind;

  modport source (output valid, kind, input ready);
  modport sink   (input valid, kind, output ready);
endinterface

FILE: rtl/srr_front.sv
// Front end: accepts packets, checks the checksum, forwards good sequence numbers.
`timescale 1ns / 1ps
module srr_front #(
  parameter int PAYLOAD_BYTES = 20
) (
  input  logic                      clk,
  input  logic                      rst,
  srr_pkt_if.sink                   pkt,
  output logic                      push_valid,
  input  logic                      push_ready,
  output logic [srr_pkg::SEQ_W-1:0] push_seq
);

  localparam int GW = srr_pkg::GROUP_W;

  // Stage 1: number sum and per-group byte sums
  logic                        s1_valid;
  logic [srr_pkg::SEQ_W-1:0]   s1_seq;
  logic [srr_pkg::CHECK_W-1:0] s1_sum;
  logic [srr_pkg::CHECK_W-1:0] s1_check;
  logic signed [GW-1:0]        s1_grp [srr_pkg::GROUPS];

  // Stage 2: verdict
  logic                        s2_valid;
  logic                        s2_good;
  logic [srr_pkg::SEQ_W-1:0]   s2_seq;

  logic [srr_pkg::PAYLOAD_W-1:0] payload_all;
  logic signed [GW-1:0]          grp_sum [srr_pkg::GROUPS];
  logic [srr_pkg::CHECK_W-1:0]   total;
  logic                          s2_leave;
  logic                          s2_free;
  logic                          s1_free;

  assign payload_all = {pkt.payload_top, pkt.payload_mid, pkt.payload_low};

  // Signed byte sums, bytes past the payload length count as zero
  always_comb begin
    int idx;
    logic signed [7:0] b;
    logic signed [GW-1:0] acc;
    for (int g = 0; g < srr_pkg::GROUPS; g++) begin
      acc = '0;
      for (int j = 0; j < srr_pkg::GROUP_LEN; j++) begin
        idx = g * srr_pkg::GROUP_LEN + j;
        b = payload_all[8*idx +: 8];
        if (idx < PAYLOAD_BYTES) begin
          acc = acc + GW'(b);
        end
      end
      grp_sum[g] = acc;
    end
  end

  // Final wrapping sum of stage 1
  always_comb begin
    logic signed [GW+1:0] gsum;
    gsum = '0;
    for (int g = 0; g < srr_pkg::GROUPS; g++) begin
      gsum = gsum + (GW+2)'(s1_grp[g]);
    end
    total = s1_sum + srr_pkg::CHECK_W'(gsum);
  end

  // Pipeline flow; corrupted packets are dropped at stage 2
  assign s2_leave = s2_valid && (!s2_good || push_ready);
  assign s2_free  = !s2_valid || s2_leave;
  assign s1_free  = !s1_valid || s2_free;
  assign pkt.ready = s1_free;

  assign push_valid = s2_valid && s2_good;
  assign push_seq   = s2_seq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= pkt.valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (pkt.valid && s1_free) begin
      s1_seq   <= pkt.seq_number;
      s1_sum   <= {1'b0, pkt.seq_number} + {1'b0, pkt.ack_number};
      s1_check <= pkt.check_value;
      s1_grp   <= grp_sum;
    end
    if (s1_valid && s2_free) begin
      s2_seq  <= s1_seq;
      s2_good <= (total == s1_check);
    end
  end

endmodule

FILE: rtl/srr_queue.sv
// Short FIFO of good sequence numbers between front and back.
`timescale 1ns / 1ps
module srr_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push_valid,
  output logic                      push_ready,
  input  logic [srr_pkg::SEQ_W-1:0] push_seq,
  output logic                      pop_valid,
  input  logic                      pop_ready,
  output logic [srr_pkg::SEQ_W-1:0] pop_seq
);

  logic [srr_pkg::SEQ_W-1:0]  mem [srr_pkg::QUEUE_DEPTH];
  logic [srr_pkg::QPTR_W-1:0] wr_ptr;
  logic [srr_pkg::QPTR_W-1:0] rd_ptr;
  logic [srr_pkg::QCNT_W-1:0] count;
  logic                       do_push;
  logic                       do_pop;

  assign push_ready = (count != srr_pkg::QCNT_W'(srr_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_seq    = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_seq;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == srr_pkg::QPTR_W'(srr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == srr_pkg::QPTR_W'(srr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/srr_back.sv
// Back end: classifies good packets against the window, emits acks and deliveries.
`timescale 1ns / 1ps
module srr_back #(
  parameter int WINDOW = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [srr_pkg::CFG_W-1:0] window_size,
  input  logic                      pop_valid,
  output logic                      pop_ready,
  input  logic [srr_pkg::SEQ_W-1:0] pop_seq,
  srr_res_if.source                 res
);

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);

  typedef enum logic [1:0] {
    S_TAKE,
    S_ACK,
    S_DRAIN
  } state_t;

  state_t                    state;
  logic                      out_valid;
  logic                      out_kind;
  logic [srr_pkg::SEQ_W-1:0] base;
  logic [SLOT_W-1:0]         base_slot;
  logic [WINDOW-1:0]         held_valid;
  logic [CNT_W-1:0]          drain_cnt;

  logic                      out_free;
  logic [srr_pkg::SEQ_W:0]   diff;
  logic [srr_pkg::SEQ_W:0]   win_ext;
  logic                      in_order;
  logic                      in_win;
  logic [SLOT_W:0]           slot_sum;
  logic [SLOT_W-1:0]         held_slot;
  logic                      base_at_max;
  logic [SLOT_W-1:0]         slot_inc;
  logic                      head_valid;
  logic                      emit;

  assign res.valid = out_valid;
  assign res.kind  = out_kind;
  assign out_free  = !out_valid || res.ready;
  assign pop_ready = (state == S_TAKE) && out_free;

  // Window classification of the queued sequence number
  always_comb begin
    win_ext = (32'(window_size) > 32'(WINDOW)) ? (srr_pkg::SEQ_W+1)'(WINDOW)
                                               : (srr_pkg::SEQ_W+1)'(window_size);
    diff     = {1'b0, pop_seq} - {1'b0, base};
    in_order = (pop_seq == base);
    in_win   = (pop_seq > base) && (diff < win_ext);
    // offset is below WINDOW when in window, so one subtract wraps the slot
    slot_sum = (SLOT_W+1)'(base_slot) + diff[SLOT_W:0];
    if (slot_sum >= (SLOT_W+1)'(WINDOW)) begin
      held_slot = SLOT_W'(slot_sum - (SLOT_W+1)'(WINDOW));
    end else begin
      held_slot = slot_sum[SLOT_W-1:0];
    end
  end

  // Base advance helpers
  assign base_at_max = (base == srr_pkg::BASE_MAX);
  assign slot_inc    = (base_slot == SLOT_W'(WINDOW - 1)) ? '0 : base_slot + 1'b1;
  assign head_valid  = held_valid[base_slot];

  // A new result is registered this cycle
  always_comb begin
    unique case (state)
      S_TAKE:  emit = pop_valid && out_free;
      S_ACK:   emit = out_free;
      S_DRAIN: emit = head_valid && (drain_cnt != CNT_W'(WINDOW)) && out_free;
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_TAKE;
      out_valid  <= 1'b0;
      out_kind   <= srr_pkg::KIND_ACK;
      base       <= '0;
      base_slot  <= '0;
      held_valid <= '0;
      drain_cnt  <= '0;
    end else begin
      out_valid <= emit || (out_valid && !res.ready);
      unique case (state)
        // Take one packet from the queue
        S_TAKE: begin
          if (pop_valid && out_free) begin
            if (in_order) begin
              out_kind <= srr_pkg::KIND_DELIVER;
              if (!base_at_max) begin
                base      <= base + 1'b1;
                base_slot <= slot_inc;
              end
              state <= S_ACK;
            end else begin
              out_kind <= srr_pkg::KIND_ACK;
              if (in_win) begin
                held_valid[held_slot] <= 1'b1;
              end
            end
          end
        end
        // Ack of the in-order packet
        S_ACK: begin
          if (out_free) begin
            out_kind  <= srr_pkg::KIND_ACK;
            drain_cnt <= '0;
            state     <= S_DRAIN;
          end
        end
        // Deliver held packets that now sit at the base
        S_DRAIN: begin
          if (!head_valid || drain_cnt == CNT_W'(WINDOW)) begin
            state <= S_TAKE;
          end else if (out_free) begin
            held_valid[base_slot] <= 1'b0;
            out_kind  <= srr_pkg::KIND_DELIVER;
            drain_cnt <= drain_cnt + 1'b1;
            if (!base_at_max) begin
              base      <= base + 1'b1;
              base_slot <= slot_inc;
            end
          end
        end
        default: begin
          state <= S_TAKE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/selective_repeat_receiver_unit.sv
// Top level of the selective repeat receiver.
`timescale 1ns / 1ps
// Selective repeat receiver.
// pkt: arriving packets (sequence, ack number, checksum, 20 payload bytes),
//   a transfer on valid and ready high. res: one kind bit per result,
//   0 for an ack to the sender, 1 for a payload delivered upward.
// cfg_we / cfg_data write the receive window width (capped at WINDOW).
// A packet passes a two-stage checksum pipeline (byte group sums, then the
// final add and compare); corrupted packets are dropped there. Good sequence
// numbers wait in a two-entry queue for the window controller.
// The first result is registered once the packet has passed both checksum
// stages and the queue. Intake takes one packet a cycle until the queue and
// the front stages are full. The window controller answers an ack-only
// packet with one ack; an in-order packet releasing n held packets gives a
// delivery, its ack and n deliveries, one result a cycle while res is ready.
// Reset: base 0, all held marks clear, window width 8, queue empty.
// A stalled res holds its result; the controller and then the queue stop,
// and the front keeps taking packets until its stages are full.
module selective_repeat_receiver_unit #(
  parameter int WINDOW        = 16,
  parameter int PAYLOAD_BYTES = 20
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [srr_pkg::CFG_W-1:0] cfg_data,
  srr_pkt_if.sink                   pkt,
  srr_res_if.source                 res
);

  logic [srr_pkg::CFG_W-1:0] window_size;
  logic                      push_valid;
  logic                      push_ready;
  logic [srr_pkg::SEQ_W-1:0] push_seq;
  logic                      pop_valid;
  logic                      pop_ready;
  logic [srr_pkg::SEQ_W-1:0] pop_seq;

  // Window width register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= srr_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      window_size <= cfg_data;
    end
  end

  srr_front #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .pkt        (pkt),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_seq   (push_seq)
  );

  srr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_seq   (push_seq),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_seq    (pop_seq)
  );

  srr_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .window_size (window_size),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_seq     (pop_seq),
    .res         (res)
  );

endmodule

FILE: sim/tb.sv
// Testbench for the selective repeat receiver: predicts ack and delivery results per packet.
`timescale 1ns / 1ps
module tb;

  localparam int RX_WINDOW   = 16;
  localparam int RX_BYTES    = 20;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE      = 16;

  typedef struct {
    logic [srr_pkg::SEQ_W-1:0]   seq;
    logic [srr_pkg::SEQ_W-1:0]   ack;
    logic [srr_pkg::CHECK_W-1:0] check;
    logic [srr_pkg::LOW_W-1:0]   low;
    logic [srr_pkg::MID_W-1:0]   mid;
    logic [srr_pkg::TOP_W-1:0]   top;
  } packet_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_we;
  logic [srr_pkg::CFG_W-1:0] cfg_data;

  srr_pkt_if pkt_ch ();
  srr_res_if res_ch ();

  selective_repeat_receiver_unit #(
    .WINDOW        (RX_WINDOW),
    .PAYLOAD_BYTES (RX_BYTES)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .pkt      (pkt_ch),
    .res      (res_ch)
  );

  // Receiver model state
  logic [srr_pkg::SEQ_W-1:0] recv_base;
  logic                      held_mark [RX_WINDOW];
  logic [srr_pkg::CFG_W-1:0] window_reg;
  logic                      pending_kinds [$];

  int   error_count;
  bit   idle_on;
  bit   hold_off_req;
  int   hold_count;
  logic want_kind;

  // Clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    error_count++;
  endtask

  // Append one expected result kind
  function automatic void add_expected(input logic kind);
    pending_kinds = {pending_kinds, kind};
  endfunction

  // 32-bit wrapping sum of both numbers and the sign-extended payload bytes
  function automatic logic [31:0] packet_sum(input packet_t p);
    logic [8*RX_BYTES-1:0] bytes;
    logic [31:0]           acc;
    int                    i;
    bytes = {p.top, p.mid, p.low};
    acc = {1'b0, p.seq} + {1'b0, p.ack};
    for (i = 0; i < RX_BYTES; i++)
      acc = acc + {{24{bytes[8*i+7]}}, bytes[8*i +: 8]};
    return acc;
  endfunction

  function automatic void advance_base();
    if (recv_base != srr_pkg::BASE_MAX) recv_base = recv_base + 1'b1;
  endfunction

  // Classify one accepted packet, queue its result kinds, drain held slots
  function automatic void receiver_predict(input packet_t p);
    longint eff;
    int     k;
    if (packet_sum(p) != p.check) return;
    eff = (window_reg < RX_WINDOW) ? window_reg : RX_WINDOW;
    if (p.seq == recv_base) begin
      add_expected(srr_pkg::KIND_DELIVER);
      add_expected(srr_pkg::KIND_ACK);
      advance_base();
    end else if (p.seq > recv_base && longint'(p.seq) < longint'(recv_base) + eff) begin
      held_mark[p.seq % RX_WINDOW] = 1'b1;
      add_expected(srr_pkg::KIND_ACK);
    end else begin
      add_expected(srr_pkg::KIND_ACK);
    end
    for (k = 0; k < RX_WINDOW; k++) begin
      if (!held_mark[recv_base % RX_WINDOW]) break;
      held_mark[recv_base % RX_WINDOW] = 1'b0;
      add_expected(srr_pkg::KIND_DELIVER);
      advance_base();
    end
  endfunction

  function automatic packet_t make_packet(input logic [srr_pkg::SEQ_W-1:0] seq,
                                          input bit corrupt);
    packet_t     p;
    logic [31:0] flip;
    p.seq   = seq;
    p.ack   = srr_pkg::SEQ_W'($urandom);
    p.low   = {$urandom, $urandom};
    p.mid   = {$urandom, $urandom};
    p.top   = $urandom;
    p.check = packet_sum(p);
    if (corrupt) begin
      flip = $urandom;
      if (flip == 0) flip = 32'h8000_0000;
      p.check = p.check ^ flip;
    end
    return p;
  endfunction

  // Offer one packet, optionally after a gap, and predict it at the transfer
  task automatic send_packet(input packet_t p);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      pkt_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    pkt_ch.valid       <= 1'b1;
    pkt_ch.seq_number  <= p.seq;
    pkt_ch.ack_number  <= p.ack;
    pkt_ch.check_value <= p.check;
    pkt_ch.payload_low <= p.low;
    pkt_ch.payload_mid <= p.mid;
    pkt_ch.payload_top <= p.top;
    do @(posedge clk); while (pkt_ch.ready !== 1'b1);
    receiver_predict(p);
  endtask

  task automatic send_seq(input logic [srr_pkg::SEQ_W-1:0] seq, input bit corrupt);
    send_packet(make_packet(seq, corrupt));
  endtask

  // Block drained: nothing expected, plus time for dropped packets in flight
  task automatic wait_idle();
    pkt_ch.valid <= 1'b0;
    while (pending_kinds.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_window(input logic [srr_pkg::CFG_W-1:0] w);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= w;
    @(posedge clk);
    cfg_we     <= 1'b0;
    window_reg = w;
  endtask

  // Shuffled window rounds with random content, mixed with noise and gaps
  task automatic send_rounds(input int item_count);
    logic [srr_pkg::SEQ_W-1:0] order [$];
    logic [srr_pkg::SEQ_W-1:0] tmp;
    int                        issued;
    int                        n;
    int                        j;
    int                        k;
    issued = 0;
    while (issued < item_count) begin
      n = (window_reg < RX_WINDOW) ? window_reg : RX_WINDOW;
      if (n == 0) n = 1;
      order.delete();
      for (j = 0; j < n; j++) order = {order, srr_pkg::SEQ_W'(recv_base + j)};
      for (j = n - 1; j > 0; j--) begin
        k        = $urandom_range(0, j);
        tmp      = order[j];
        order[j] = order[k];
        order[k] = tmp;
      end
      while (order.size() != 0 && issued < item_count) begin
        case ($urandom_range(0, 11))
          0: send_seq(srr_pkg::SEQ_W'(recv_base + $urandom_range(0, n)), 1'b1);
          1: begin
            send_seq(srr_pkg::SEQ_W'($urandom), 1'b0);
            issued++;
          end
          2: begin
            if (recv_base != 0)
              send_seq(srr_pkg::SEQ_W'($urandom_range(0, recv_base - 1)), 1'b0);
            else send_seq(recv_base, 1'b0);
            issued++;
          end
          3: begin
            send_seq(srr_pkg::SEQ_W'(recv_base + $urandom_range(1, RX_WINDOW + 1)), 1'b0);
            issued++;
          end
          4: begin
            // broken round: one time in three this packet is lost
            if ($urandom_range(0, 2) == 0) order.delete(0);
          end
          default: begin
            tmp = order[0];
            order.delete(0);
            send_seq(tmp, 1'b0);
            issued++;
          end
        endcase
      end
    end
  endtask

  // Field extremes, both checksum extremes, hold, overwrite, window edge, stale
  task automatic test_field_extremes();
    packet_t                   p;
    logic [srr_pkg::SEQ_W-1:0] b;
    idle_on = 1'b0;
    p.seq = '0; p.ack = '0; p.low = '0; p.mid = '0; p.top = '0; p.check = '0;
    send_packet(p);
    p.seq = srr_pkg::BASE_MAX; p.ack = srr_pkg::SEQ_W'(1); p.check = 32'h8000_0000;
    send_packet(p);
    p.ack = '0; p.check = 32'h7FFF_FFFF;
    send_packet(p);
    p.seq = recv_base; p.ack = '1; p.low = '1; p.mid = '1; p.top = '1;
    p.check = packet_sum(p);
    send_packet(p);
    b = recv_base;
    send_seq(b, 1'b1);
    send_seq(srr_pkg::SEQ_W'(b + 1), 1'b0);
    send_seq(srr_pkg::SEQ_W'(b + 1), 1'b0);
    send_seq(srr_pkg::SEQ_W'(b + 7), 1'b0);
    send_seq(srr_pkg::SEQ_W'(b + 8), 1'b0);
    send_seq(srr_pkg::SEQ_W'(b + 3), 1'b0);
    send_seq(b, 1'b0);
    send_seq(srr_pkg::SEQ_W'(b + 2), 1'b0);
    send_seq('0, 1'b0);
  endtask

  // Fill a full window from the top, then the in-order packet drains it all
  task automatic test_full_window_drain();
    logic [srr_pkg::SEQ_W-1:0] b;
    int                        j;
    set_window(5'd16);
    idle_on = 1'b1;
    b = recv_base;
    for (j = RX_WINDOW - 1; j >= 1; j--) send_seq(srr_pkg::SEQ_W'(b + j), 1'b0);
    send_seq(b, 1'b0);
  endtask

  // Random rounds across window settings, including zero and wide windows
  task automatic test_random_windows();
    logic [srr_pkg::CFG_W-1:0] phase_windows [8];
    int                        i;
    phase_windows = '{5'd31, 5'd5, 5'd0, 5'd16, 5'd1, 5'd12, 5'd17, 5'd8};
    for (i = 0; i < 8; i++) begin
      set_window(phase_windows[i]);
      idle_on = (i % 3 != 2);
      send_rounds(18);
    end
  endtask

  // Receiver holds off while packets keep coming, so intake must stall
  task automatic test_receiver_hold_off();
    set_window(5'd16);
    idle_on      = 1'b0;
    hold_off_req = 1'b1;
    send_rounds(30);
  endtask

  // Last stretch without any idling
  task automatic test_steady_stream();
    set_window(5'd8);
    idle_on = 1'b0;
    send_rounds(20);
  endtask

  // Result side ready: random stall bursts and one long hold-off
  initial begin
    res_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        res_ch.ready <= 1'b0;
        for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(posedge clk);
        res_ch.ready <= 1'b1;
        hold_off_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each result transfer with the oldest expected kind
  always @(posedge clk) begin
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (pending_kinds.size() == 0) begin
        report_mismatch($sformatf("unexpected result, kind %b", res_ch.kind));
      end else begin
        want_kind = pending_kinds[0];
        pending_kinds.delete(0);
        if (res_ch.kind !== want_kind)
          report_mismatch($sformatf("kind %b, expected %b", res_ch.kind, want_kind));
      end
    end
  end

  // Main sequence
  initial begin
    error_count  = 0;
    idle_on      = 1'b0;
    hold_off_req = 1'b0;
    recv_base    = '0;
    window_reg   = srr_pkg::WINDOW_RESET;
    foreach (held_mark[i]) held_mark[i] = 1'b0;
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_data           <= '0;
    pkt_ch.valid       <= 1'b0;
    pkt_ch.seq_number  <= '0;
    pkt_ch.ack_number  <= '0;
    pkt_ch.check_value <= '0;
    pkt_ch.payload_low <= '0;
    pkt_ch.payload_mid <= '0;
    pkt_ch.payload_top <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_field_extremes();
    test_full_window_drain();
    test_random_windows();
    test_receiver_hold_off();
    test_steady_stream();

    wait_idle();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Timeout
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
